[rtl/core/skmap_pkg.sv]
// ----------------------------------------------------------------------------
// skmap_pkg
// Shared types, codes and scale tables for the scale keyboard note mapper.
// ----------------------------------------------------------------------------
package skmap_pkg;

  // default sizes
  localparam int NUM_KEYS_DEF = 8;
  localparam int Q_DEPTH_DEF  = 2;

  // field widths
  localparam int OP_W       = 3;
  localparam int KEY_IDX_W  = 3;
  localparam int MODE_W     = 2;
  localparam int POT_W      = 10;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  // input op codes
  localparam logic [OP_W-1:0] OP_PRESS   = 3'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
  localparam logic [OP_W-1:0] OP_OCT_UP  = 3'd2;
  localparam logic [OP_W-1:0] OP_OCT_DN  = 3'd3;
  localparam logic [OP_W-1:0] OP_ASSIGN  = 3'd4;

  // panel modes
  localparam logic [MODE_W-1:0] MODE_PLAY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SHIFT = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY = 4'd3;

  // status byte high nibbles
  localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
  localparam logic [3:0] STAT_NOTE_OFF = 4'h8;

  // register limits
  localparam int         SCALE_CNT  = 24;
  localparam logic [4:0] SCALE_LAST = 5'd23;
  localparam logic [3:0] ROOT_LAST  = 4'd11;
  localparam logic [6:0] NOTE_MAX   = 7'd127;

  // classified command kinds
  typedef enum logic [2:0] {
    CMD_PRESS,
    CMD_RELEASE,
    CMD_OCT_UP,
    CMD_OCT_DN,
    CMD_ASSIGN,
    CMD_REPOS
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [KEY_IDX_W-1:0] key;
    logic [POT_W-1:0]     pot;
  } cmd_t;

  // steps per octave of each scale
  localparam logic [3:0] SCALE_LEN [SCALE_CNT] = '{
    4'd12, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd5, 4'd5,
    4'd6,  4'd6, 4'd6, 4'd8, 4'd8, 4'd7, 4'd7, 4'd7, 4'd5, 4'd5, 4'd5, 4'd5
  };

  // degree i of each scale sits in nibble i
  localparam logic [47:0] SCALE_DEG [SCALE_CNT] = '{
    48'hBA9876543210, 48'h00000B975420, 48'h00000A875320, 48'h00000B875320,
    48'h00000B975320, 48'h00000A975320, 48'h00000A875310, 48'h00000B976420,
    48'h00000A975420, 48'h00000A865310, 48'h000000097420, 48'h0000000A7530,
    48'h000000A76530, 48'h000000974320, 48'h000000A86420, 48'h0000B9865320,
    48'h0000A9764310, 48'h00000A875410, 48'h00000B876320, 48'h00000B875410,
    48'h000000087320, 48'h0000000A7510, 48'h0000000A6510, 48'h000000097520
  };

  function automatic logic [3:0] scale_len(input logic [4:0] sel);
    return SCALE_LEN[sel];
  endfunction

  function automatic logic [3:0] scale_deg(input logic [4:0] sel, input logic [3:0] idx);
    logic [47:0] row;
    row = SCALE_DEG[sel];
    return row[{idx, 2'b00} +: 4];
  endfunction

endpackage

[rtl/core/skmap_if.sv]
// ----------------------------------------------------------------------------
// skmap channel interfaces
// Valid/ready channels for key events, MIDI messages and register writes.
// ----------------------------------------------------------------------------

// key event channel
interface skmap_in_if import skmap_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [KEY_IDX_W-1:0] key_index;
  logic [MODE_W-1:0]    panel_mode;
  logic [POT_W-1:0]     pot_level;

  modport source (output valid, op, key_index, panel_mode, pot_level, input ready);
  modport sink   (input valid, op, key_index, panel_mode, pot_level, output ready);
endinterface

// midi message channel
interface skmap_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] status_byte;
  logic [6:0] note_number;
  logic [6:0] velocity_byte;

  modport source (output valid, status_byte, note_number, velocity_byte, input ready);
  modport sink   (input valid, status_byte, note_number, velocity_byte, output ready);
endinterface

// register write channel
interface skmap_cfg_if import skmap_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/skmap_queue.sv]
// ----------------------------------------------------------------------------
// skmap_queue
// Short command queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module skmap_queue import skmap_pkg::*; #(
  parameter int DEPTH = Q_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  // handshake on both sides
  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/skmap_front.sv]
// ----------------------------------------------------------------------------
// skmap_front
// Accepts key events, drops those with no effect and classifies the rest.
// ----------------------------------------------------------------------------
module skmap_front import skmap_pkg::*; #(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  skmap_in_if.sink in_ch,
  output logic     push_valid,
  input  logic     push_ready,
  output cmd_t     push_cmd
);

  logic      key_ok;
  logic      keep;
  cmd_kind_t kind;

  assign key_ok = (32'(in_ch.key_index) < NUM_KEYS);

  // classify the event
  always_comb begin
    keep = 1'b0;
    kind = CMD_PRESS;
    unique case (in_ch.op)
      OP_PRESS: begin
        if (key_ok && in_ch.panel_mode == MODE_PLAY) begin
          keep = 1'b1;
          kind = CMD_PRESS;
        end else if (key_ok && in_ch.panel_mode == MODE_SHIFT && in_ch.key_index == '0) begin
          keep = 1'b1;
          kind = CMD_REPOS;
        end
      end
      OP_RELEASE: begin
        keep = key_ok;
        kind = CMD_RELEASE;
      end
      OP_OCT_UP: begin
        keep = (in_ch.panel_mode == MODE_PLAY);
        kind = CMD_OCT_UP;
      end
      OP_OCT_DN: begin
        keep = (in_ch.panel_mode == MODE_PLAY);
        kind = CMD_OCT_DN;
      end
      OP_ASSIGN: begin
        keep = key_ok;
        kind = CMD_ASSIGN;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // events that do nothing are taken and dropped here
  assign in_ch.ready   = push_ready;
  assign push_valid    = in_ch.valid && keep;
  assign push_cmd.kind = kind;
  assign push_cmd.key  = in_ch.key_index;
  assign push_cmd.pot  = in_ch.pot_level;

endmodule

[rtl/core/skmap_back.sv]
// ----------------------------------------------------------------------------
// skmap_back
// Executes commands: key positions, held notes, octave shift, note messages.
// ----------------------------------------------------------------------------
module skmap_back import skmap_pkg::*; #(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  cmd_t          q_cmd,
  skmap_cfg_if.sink     cfg_ch,
  skmap_out_if.source   out_ch
);

  localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_NOTE, ST_EMIT} state_t;

  state_t              state_r;
  logic [4:0]          scale_r;
  logic [3:0]          root_r;
  logic [3:0]          chan_r;
  logic [6:0]          vel_r;
  logic                rebuild_r;
  logic signed [2:0]   oct_r;
  logic [6:0]          top_r;
  logic [6:0]          key_step_r [NUM_KEYS];
  logic [NUM_KEYS-1:0] sound_on_r;
  logic [6:0]          sound_note_r [NUM_KEYS];
  logic [KEY_W-1:0]    cur_key_r;
  logic [6:0]          quo_r;
  logic [3:0]          rem_r;
  logic [2:0]          cnt_r;
  logic                res_on_r;
  logic [6:0]          res_note_r;
  logic                out_valid_r;
  logic [7:0]          out_status_r;
  logic [6:0]          out_note_r;
  logic [6:0]          out_vel_r;

  logic [3:0]          len;
  logic [KEY_W-1:0]    key_sel;
  logic [4:0]          cfg_scale;
  logic [3:0]          cfg_root;
  logic [6:0]          cfg_vel;
  logic                cfg_rebuild;
  logic [4:0]          trial;
  logic                trial_ge;
  logic [3:0]          rem_step;
  logic [3:0]          deg;
  logic [4:0]          pc_sum;
  logic                pc_wrap;
  logic [3:0]          pc;
  logic signed [7:0]   oct_num;
  logic [8:0]          raw_note;
  logic [6:0]          note_val;
  logic [3:0]          oct_cnt;
  logic [3:0]          rem_room;
  logic [3:0]          fit_cnt;
  logic [7:0]          top_sum;
  logic [6:0]          top_new;
  logic [7:0]          top_inc;
  logic [17:0]         assign_prod;
  logic [6:0]          assign_step;
  logic [6:0]          repos_val [NUM_KEYS];
  logic                out_free;
  logic                emit_go;

  assign len      = scale_len(scale_r);
  assign key_sel  = KEY_W'(q_cmd.key);
  assign q_ready  = (state_r == ST_IDLE) && !rebuild_r;
  assign out_free = !out_valid_r || out_ch.ready;
  assign emit_go  = (state_r == ST_EMIT) && out_free;

  // register write clamping
  assign cfg_ch.ready = 1'b1;
  assign cfg_scale = (cfg_ch.data[4:0] > SCALE_LAST) ? SCALE_LAST : cfg_ch.data[4:0];
  assign cfg_root  = (cfg_ch.data[3:0] > ROOT_LAST) ? ROOT_LAST : cfg_ch.data[3:0];
  assign cfg_vel   = (cfg_ch.data[6:0] == 7'd0) ? 7'd1 : cfg_ch.data[6:0];
  assign cfg_rebuild = cfg_ch.valid
                     && (cfg_ch.index == CFG_SCALE || cfg_ch.index == CFG_ROOT);

  // one restoring division step of the key position by the scale length
  assign trial    = {rem_r, quo_r[6]};
  assign trial_ge = (trial >= {1'b0, len});
  assign rem_step = trial_ge ? 4'(trial - {1'b0, len}) : trial[3:0];

  // pitch class and octave of the played note, folded into the midi range
  always_comb begin
    deg      = scale_deg(scale_r, rem_r);
    pc_sum   = {1'b0, root_r} + {1'b0, deg};
    pc_wrap  = (pc_sum >= 5'd12);
    pc       = pc_wrap ? 4'(pc_sum - 5'd12) : pc_sum[3:0];
    oct_num  = $signed({1'b0, quo_r}) + $signed({{5{oct_r[2]}}, oct_r})
             + $signed({7'd0, pc_wrap});
    raw_note = 9'(oct_num[4:0]) * 9'd12 + 9'(pc);
    if (oct_num[7]) begin
      note_val = {3'd0, pc};
    end else if (raw_note <= 9'(NOTE_MAX)) begin
      note_val = raw_note[6:0];
    end else if (pc <= 4'd7) begin
      note_val = 7'd120 + 7'(pc);
    end else begin
      note_val = 7'd108 + 7'(pc);
    end
  end

  // highest step whose note stays at or below the top of the midi range
  always_comb begin
    oct_cnt  = (root_r <= 4'd7) ? 4'd10 : 4'd9;
    rem_room = (root_r <= 4'd7) ? 4'(5'd7 - {1'b0, root_r}) : 4'(5'd19 - {1'b0, root_r});
    fit_cnt  = '0;
    for (int i = 0; i < 12; i++) begin
      if (4'(i) < len && scale_deg(scale_r, 4'(i)) <= rem_room) begin
        fit_cnt = fit_cnt + 1'b1;
      end
    end
    top_sum = 8'({4'd0, oct_cnt} * {4'd0, len}) + {4'd0, fit_cnt} - 8'd1;
    top_new = (top_sum > {1'b0, NOTE_MAX}) ? NOTE_MAX : top_sum[6:0];
  end

  // pot to step, clamped to the top step
  always_comb begin
    top_inc     = {1'b0, top_r} + 8'd1;
    assign_prod = {8'd0, q_cmd.pot} * {10'd0, top_inc};
    assign_step = (assign_prod[17:10] > {1'b0, top_r}) ? top_r : assign_prod[16:10];
  end

  // home positions: five octaves up plus the key number
  always_comb begin
    for (int j = 0; j < NUM_KEYS; j++) begin
      repos_val[j] = 7'({3'd0, len} * 7'd5) + 7'(j);
    end
  end

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scale_r     <= '0;
      root_r      <= '0;
      chan_r      <= '0;
      vel_r       <= NOTE_MAX;
      rebuild_r   <= 1'b0;
      oct_r       <= '0;
      top_r       <= NOTE_MAX;
      sound_on_r  <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < NUM_KEYS; j++) begin
        key_step_r[j] <= 7'(60 + j);
      end
    end else begin
      // load a new message, or drop the one taken downstream
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      // a scale or root write asks for a rebuild, served while idle
      if (cfg_rebuild) begin
        rebuild_r <= 1'b1;
      end else if (state_r == ST_IDLE) begin
        rebuild_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (rebuild_r) begin
            top_r <= top_new;
            for (int j = 0; j < NUM_KEYS; j++) begin
              key_step_r[j] <= repos_val[j];
            end
          end else if (q_valid) begin
            unique case (q_cmd.kind)
              CMD_PRESS: begin
                if (!sound_on_r[key_sel]) begin
                  cur_key_r <= key_sel;
                  quo_r     <= key_step_r[key_sel];
                  rem_r     <= '0;
                  cnt_r     <= '0;
                  state_r   <= ST_DIV;
                end
              end
              CMD_RELEASE: begin
                if (sound_on_r[key_sel]) begin
                  sound_on_r[key_sel] <= 1'b0;
                  res_on_r            <= 1'b0;
                  res_note_r          <= sound_note_r[key_sel];
                  state_r             <= ST_EMIT;
                end
              end
              CMD_OCT_UP: begin
                if (oct_r != 3'sd3) begin
                  oct_r <= oct_r + 3'sd1;
                end
              end
              CMD_OCT_DN: begin
                if (oct_r != -3'sd3) begin
                  oct_r <= oct_r - 3'sd1;
                end
              end
              CMD_ASSIGN: begin
                key_step_r[key_sel] <= assign_step;
              end
              CMD_REPOS: begin
                for (int j = 0; j < NUM_KEYS; j++) begin
                  key_step_r[j] <= repos_val[j];
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_DIV: begin
          rem_r <= rem_step;
          quo_r <= {quo_r[5:0], trial_ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 3'd6) begin
            state_r <= ST_NOTE;
          end
        end
        ST_NOTE: begin
          sound_on_r[cur_key_r]   <= 1'b1;
          sound_note_r[cur_key_r] <= note_val;
          res_on_r                <= 1'b1;
          res_note_r              <= note_val;
          state_r                 <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_status_r <= {res_on_r ? STAT_NOTE_ON : STAT_NOTE_OFF, chan_r};
            out_note_r   <= res_note_r;
            out_vel_r    <= res_on_r ? vel_r : 7'd0;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      // register writes, expected only while no event is in flight
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_SCALE: begin
            scale_r <= cfg_scale;
          end
          CFG_ROOT: begin
            root_r <= cfg_root;
          end
          CFG_CHANNEL: begin
            chan_r <= cfg_ch.data[3:0];
          end
          CFG_VELOCITY: begin
            vel_r <= cfg_vel;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status_byte   = out_status_r;
  assign out_ch.note_number   = out_note_r;
  assign out_ch.velocity_byte = out_vel_r;

endmodule

[rtl/core/scale_keyboard_note_mapper_core.sv]
// ----------------------------------------------------------------------------
// scale_keyboard_note_mapper_core
// Maps play key events to MIDI note-on and note-off messages on a scale.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : key events (press, release, octave up/down, pot step assign).
//   out_ch : at most one MIDI message per event (status, note, velocity).
//   cfg_ch : register writes (scale, root, channel, velocity), always ready;
//            write only while no event is in flight.
// Events pass a classifier, then a two-entry queue, then the executing
// sequencer. Events with no effect are dropped by the classifier.
// From acceptance to a valid message, a note-on passes the queue, the steps of
// the step/length divider, the note step and the load step; a note-off passes
// the queue and the load step. The sequencer takes one event at a time; octave,
// assign and position reset events are executed in its idle state.
// A scale or root write triggers a rebuild of the top step and the key
// positions in the idle state, during which queued events wait.
// Reset gives chromatic on C, keys at notes 60 upward, all keys silent.
// A stalled receiver holds the message register; the sequencer then waits
// in its load step and the queue fills before in_ch drops ready.
// ----------------------------------------------------------------------------
module scale_keyboard_note_mapper_core import skmap_pkg::*; #(
  parameter int NUM_KEYS    = NUM_KEYS_DEF,
  parameter int QUEUE_DEPTH = Q_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  skmap_in_if.sink    in_ch,
  skmap_out_if.source out_ch,
  skmap_cfg_if.sink   cfg_ch
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  // classify incoming events
  skmap_front #(.NUM_KEYS(NUM_KEYS)) u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // decoupling queue
  skmap_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // execute commands
  skmap_back #(.NUM_KEYS(NUM_KEYS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (pop_valid),
    .q_ready (pop_ready),
    .q_cmd   (pop_cmd),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch)
  );

endmodule

[rtl/core/skmap_checker.sv]
// ----------------------------------------------------------------------------
// skmap_checker
// Port-level checks on the MIDI message channel against register writes.
// ----------------------------------------------------------------------------
module skmap_checker import skmap_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [7:0]            out_status,
  input logic [6:0]            out_note,
  input logic [6:0]            out_vel,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  logic [3:0] chan_r;
  logic [6:0] vel_r;

  // shadow of the channel and velocity registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= '0;
      vel_r  <= NOTE_MAX;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_CHANNEL) begin
        chan_r <= cfg_data[3:0];
      end
      if (cfg_index == CFG_VELOCITY) begin
        vel_r <= (cfg_data[6:0] == 7'd0) ? 7'd1 : cfg_data[6:0];
      end
    end
  end

  // no message straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("message valid right after reset");

  // stalled message holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_note) && $stable(out_vel))
    else $error("stalled message changed");

  // channel follows the last channel write
  a_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status[3:0] == chan_r)
    else $error("message channel differs from register");

  // note-on carries the velocity register, note-off carries zero
  a_velocity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status[7:4] == STAT_NOTE_ON && out_vel == vel_r)
      || (out_status[7:4] == STAT_NOTE_OFF && out_vel == 7'd0))
    else $error("bad status or velocity");

endmodule

bind scale_keyboard_note_mapper_core skmap_checker u_skmap_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status_byte),
  .out_note   (out_ch.note_number),
  .out_vel    (out_ch.velocity_byte),
  .cfg_valid  (cfg_ch.valid),
  .cfg_ready  (cfg_ch.ready),
  .cfg_index  (cfg_ch.index),
  .cfg_data   (cfg_ch.data)
);
